// ----- hw/rtl/key_debounce_repeat_fifo_macros.svh -----
// assertion macros for the keypad debounce / auto-repeat block
// used by key_debounce_repeat_fifo.sv; no other dependencies
`ifndef KEY_DEBOUNCE_REPEAT_FIFO_MACROS_SVH
`define KEY_DEBOUNCE_REPEAT_FIFO_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kdr assertion failed");

// next-cycle implication
`define KDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kdr assertion failed");

`else

`define KDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define KDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ----- hw/rtl/kdr_pkg.sv -----
// shared types, constants and the key code table of the keypad block
// no dependencies
package kdr_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 32;
    localparam int unsigned BUF_DEPTH       = 4;
    localparam int unsigned BUF_AW          = $clog2(BUF_DEPTH);
    localparam int unsigned BUF_LW          = BUF_AW + 1;

    localparam logic [3:0]  IDLE_PATTERN       = 4'hF;
    localparam logic [7:0]  DEBOUNCE_LIMIT_RST = 8'd20;
    localparam logic [15:0] REPEAT_DELAY_RST   = 16'd700;
    localparam logic [7:0]  REPEAT_INTV_RST    = 8'd50;

    // register indexes
    localparam logic [1:0] CFG_DEBOUNCE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_REPEAT_DELAY   = 2'd1;
    localparam logic [1:0] CFG_REPEAT_INTV    = 2'd2;

    // item modes
    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    // priority map from active-low pin pattern to key code
    localparam logic [2:0] CODE_TABLE [16] = '{
        3'd1, 3'd2, 3'd1, 3'd3,
        3'd1, 3'd2, 3'd1, 3'd4,
        3'd1, 3'd2, 3'd1, 3'd3,
        3'd1, 3'd2, 3'd1, 3'd0
    };

    typedef struct packed {
        logic [7:0]  debounce_limit;
        logic [15:0] repeat_delay;
        logic [7:0]  repeat_intv;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [2:0] code;
    } t_push;

    typedef struct packed {
        logic       read_valid;
        logic [2:0] read_code;
        logic [4:0] queued_count;
        logic [2:0] current_code;
    } t_result;

    function automatic logic [2:0] code_of(input logic [3:0] pattern);
        return CODE_TABLE[pattern];
    endfunction

endpackage

// ----- hw/rtl/kdr_filter.sv -----
// debounce filter and auto-repeat timing of the keypad block
// depends on kdr_pkg
module kdr_filter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_tick,
    input  logic [3:0]          i_pins,
    input  kdr_pkg::t_cfg       i_cfg,
    output kdr_pkg::t_push      o_push,
    output logic [2:0]          o_cur_code
);
    import kdr_pkg::*;

    logic [3:0]  r_stable, n_stable;
    logic [7:0]  r_fc, n_fc;
    logic        r_held, n_held;
    logic [15:0] r_dc, n_dc;
    logic [7:0]  r_rc, n_rc;
    logic [7:0]  w_fc_inc;
    logic [15:0] w_dc_inc;
    logic [2:0]  w_code;

    assign w_code     = code_of(n_stable);
    assign o_cur_code = w_code;

    always_comb begin
        n_stable    = r_stable;
        n_fc        = r_fc;
        n_held      = r_held;
        n_dc        = r_dc;
        n_rc        = r_rc;
        w_fc_inc    = r_fc;
        w_dc_inc    = r_dc;
        o_push      = '0;
        if (i_tick) begin
            // up/down filter on the raw pattern
            if (i_pins != r_stable) begin
                w_fc_inc = (r_fc < i_cfg.debounce_limit) ? r_fc + 8'd1 : r_fc;
                if (w_fc_inc >= i_cfg.debounce_limit) begin
                    n_stable = i_pins;
                    n_fc     = '0;
                end else begin
                    n_fc = w_fc_inc;
                end
            end else if (r_fc != '0) begin
                n_fc = r_fc - 8'd1;
            end
            // press / hold / release
            if (r_held) begin
                if (n_stable != IDLE_PATTERN) begin
                    w_dc_inc = (r_dc < i_cfg.repeat_delay) ? r_dc + 16'd1 : r_dc;
                    n_dc     = w_dc_inc;
                    if (w_dc_inc >= i_cfg.repeat_delay) begin
                        if (r_rc < i_cfg.repeat_intv) begin
                            n_rc = r_rc + 8'd1;
                        end else begin
                            n_rc         = '0;
                            o_push.valid = 1'b1;
                        end
                    end
                end else begin
                    n_dc   = '0;
                    n_rc   = '0;
                    n_held = 1'b0;
                end
            end else if (n_stable != IDLE_PATTERN) begin
                n_held       = 1'b1;
                n_dc         = '0;
                n_rc         = '0;
                o_push.valid = 1'b1;
            end
        end
        o_push.code = code_of(n_stable);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stable <= IDLE_PATTERN;
            r_fc     <= '0;
            r_held   <= 1'b0;
            r_dc     <= '0;
            r_rc     <= '0;
        end else begin
            r_stable <= n_stable;
            r_fc     <= n_fc;
            r_held   <= n_held;
            r_dc     <= n_dc;
            r_rc     <= n_rc;
        end
    end

endmodule

// ----- hw/rtl/kdr_ring.sv -----
// key code ring queue: memory, read/write pointers and fill count
// depends on kdr_pkg
module kdr_ring #(
    parameter int unsigned QUEUE_DEPTH = kdr_pkg::QUEUE_DEPTH_DEF,
    localparam int unsigned AW = $clog2(QUEUE_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  kdr_pkg::t_push      i_push,
    input  logic                i_pop,
    output logic                o_pop_ok,
    output logic [2:0]          o_rd_code,
    output logic [AW-1:0]       o_level,
    output logic [4:0]          o_queued
);
    import kdr_pkg::*;

    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    logic [2:0]    r_ring [QUEUE_DEPTH];
    logic [2:0]    r_q;
    logic [AW-1:0] r_rd, n_rd;
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    logic          w_push_ok;

    function automatic logic [AW-1:0] next_idx(input logic [AW-1:0] idx);
        return (idx == LAST) ? '0 : idx + AW'(1);
    endfunction

    function automatic logic [AW-1:0] fill(input logic [AW-1:0] rd, input logic [AW-1:0] wr);
        logic [AW:0] t;
        t = (rd > wr) ? (AW+1)'(QUEUE_DEPTH) - {1'b0, rd} + {1'b0, wr}
                      : {1'b0, wr} - {1'b0, rd};
        return t[AW-1:0];
    endfunction

    assign w_rd_addr = next_idx(r_rd);
    assign w_wr_addr = next_idx(r_wr);
    assign o_pop_ok  = i_pop && (r_wr != r_rd);
    // drop on full, one slot always kept free
    assign w_push_ok = i_push.valid && (w_wr_addr != r_rd);
    assign n_rd      = o_pop_ok  ? w_rd_addr : r_rd;
    assign n_wr      = w_push_ok ? w_wr_addr : r_wr;
    assign o_level   = fill(r_rd, r_wr);
    assign o_queued  = 5'(fill(n_rd, n_wr));
    assign o_rd_code = r_q;

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_ring[w_wr_addr] <= i_push.code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop_ok) begin
            r_q <= r_ring[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= '0;
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

endmodule

// ----- hw/rtl/kdr_outbuf.sv -----
// small result queue that decouples the result channel from the pipeline
// depends on kdr_pkg
module kdr_outbuf (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  kdr_pkg::t_result            i_data,
    output logic                        o_valid,
    input  logic                        i_ready,
    output kdr_pkg::t_result            o_data,
    output logic [kdr_pkg::BUF_LW-1:0]  o_level
);
    import kdr_pkg::*;

    t_result           r_buf [BUF_DEPTH];
    logic [BUF_AW-1:0] r_wp;
    logic [BUF_AW-1:0] r_rp;
    logic [BUF_LW-1:0] r_level;
    logic              w_pop;

    assign o_valid = (r_level != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = r_buf[r_rp];
    assign o_level = r_level;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_level <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + BUF_AW'(1);
            end
            if (w_pop) begin
                r_rp <= r_rp + BUF_AW'(1);
            end
            r_level <= r_level + BUF_LW'(i_push) - BUF_LW'(w_pop);
        end
    end

endmodule

// ----- hw/rtl/key_debounce_repeat_fifo.sv -----
// Four-key keypad qualifier: debounce, auto-repeat and a queue of key codes.
// Input channel (i_valid/o_ready) carries beats of {i_mode, i_pins}: mode tick
// samples the active-low pins, mode pop takes one code from the queue.
// Result channel (o_valid/i_ready) returns one beat per input beat, in order:
// popped code and its valid flag, queue fill after the beat, current key code.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0 debounce
// limit, 1 repeat delay, 2 repeat interval) at once; other indexes are ignored.
// Throughput: one beat per cycle while o_ready is high. A beat accepted on the
// input channel passes the stage register, loaded together with the queue memory
// read, and then the result queue before it is shown on o_valid.
// Stall: a four-entry result queue absorbs beats in flight; o_ready drops only
// when it and the stage register hold four results. o_ready does not depend
// on i_ready in the same cycle.
// Reset (synchronous, i_rst_n low): all-released pattern, counters and queue
// pointers cleared, registers back to 20/700/50; o_ready rises in the cycle
// after reset is released. The code memory itself is not cleared.
`include "key_debounce_repeat_fifo_macros.svh"
module key_debounce_repeat_fifo #(
    parameter int unsigned QUEUE_DEPTH = kdr_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_mode,
    input  logic [3:0]  i_pins,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_read_valid,
    output logic [2:0]  o_read_code,
    output logic [4:0]  o_queued_count,
    output logic [2:0]  o_current_code,
    // config write port
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data
);
    import kdr_pkg::*;

    localparam int unsigned   AW        = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] RING_LAST = AW'(QUEUE_DEPTH - 1);

    t_cfg              r_cfg;
    logic              r_run;
    logic              w_in_acc;
    logic              w_tick;
    logic              w_pop_req;
    t_push             w_push;
    logic [2:0]        w_cur_code;
    logic              w_pop_ok;
    logic [2:0]        w_rd_code;
    logic [AW-1:0]     w_ring_level;
    logic [4:0]        w_queued;
    logic [BUF_LW-1:0] w_buf_level;
    t_result           w_p_res;
    t_result           w_out;

    // stage register between item logic and result queue
    logic              r_p_valid;
    logic              r_p_pop;
    logic [4:0]        r_p_count;
    logic [2:0]        r_p_cur;

    // accept only when every result in flight has a slot waiting
    assign o_ready   = r_run &&
                       ((BUF_LW'(w_buf_level) + BUF_LW'(r_p_valid)) < BUF_LW'(BUF_DEPTH));
    assign w_in_acc  = i_valid && o_ready;
    assign w_tick    = w_in_acc && (i_mode == MODE_TICK);
    assign w_pop_req = w_in_acc && (i_mode == MODE_POP);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit <= DEBOUNCE_LIMIT_RST;
            r_cfg.repeat_delay   <= REPEAT_DELAY_RST;
            r_cfg.repeat_intv    <= REPEAT_INTV_RST;
            r_run                <= 1'b0;
        end else begin
            r_run <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_DEBOUNCE_LIMIT: r_cfg.debounce_limit <= i_cfg_data[7:0];
                    CFG_REPEAT_DELAY:   r_cfg.repeat_delay   <= i_cfg_data;
                    CFG_REPEAT_INTV:    r_cfg.repeat_intv    <= i_cfg_data[7:0];
                    default: begin
                        // unknown index: no register
                    end
                endcase
            end
        end
    end

    kdr_filter u_filter (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (w_tick),
        .i_pins     (i_pins),
        .i_cfg      (r_cfg),
        .o_push     (w_push),
        .o_cur_code (w_cur_code)
    );

    kdr_ring #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (w_push),
        .i_pop     (w_pop_req),
        .o_pop_ok  (w_pop_ok),
        .o_rd_code (w_rd_code),
        .o_level   (w_ring_level),
        .o_queued  (w_queued)
    );

    // stage register; memory read data lands in the ring at the same edge
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_p_pop   <= w_pop_ok;
            r_p_count <= w_queued;
            r_p_cur   <= w_cur_code;
        end
    end

    always_comb begin
        w_p_res.read_valid   = r_p_pop;
        w_p_res.read_code    = r_p_pop ? w_rd_code : 3'd0;
        w_p_res.queued_count = r_p_count;
        w_p_res.current_code = r_p_cur;
    end

    kdr_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_p_valid),
        .i_data  (w_p_res),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (w_out),
        .o_level (w_buf_level)
    );

    assign o_read_valid   = w_out.read_valid;
    assign o_read_code    = w_out.read_code;
    assign o_queued_count = w_out.queued_count;
    assign o_current_code = w_out.current_code;

    // every accepted beat reaches the stage register next cycle
    `KDR_ASSERT_NXT(a_acc_to_stage, i_clk, i_rst_n, w_in_acc, r_p_valid)
    // a full result queue never receives another result
    `KDR_ASSERT_IMP(a_buf_no_overflow, i_clk, i_rst_n, w_buf_level == BUF_LW'(BUF_DEPTH), !r_p_valid)
    // pop from an empty queue reports no code
    `KDR_ASSERT_NXT(a_empty_pop, i_clk, i_rst_n, w_pop_req && (w_ring_level == '0), r_p_valid && !r_p_pop)
    // ring never fills its last slot
    `KDR_ASSERT_IMP(a_ring_fill, i_clk, i_rst_n, 1'b1, w_ring_level <= RING_LAST)

endmodule
